/* rtl/core/i2cram_pkg.sv */
package i2cram_pkg;

    // Request codes carried in the cmd field; code three means tick only.
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd200;
    localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd5000;

    // Longest burst read; longer requests saturate here.
    localparam logic [7:0] MAX_BURST = 8'd255;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] read_len;
        logic       sda_sample;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy_res;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       read_last;
        logic       done_res;
        logic       status;
    } result_t;

    typedef struct packed {
        logic [15:0] half_period;
        logic [15:0] ack_timeout;
    } timing_t;

endpackage

/* rtl/core/i2c_register_access_master.sv */
// Channel   Direction  Handshake            Word
// -------   ---------  -------------------  ------------------------------------------
// in        input      in_valid / in_stall  cmd, dev_addr, reg_addr, write_data,
//                                           read_len, sda_sample (one timing tick)
// out       output     out_valid/out_stall  scl_level, sda_pull_low, busy_res, read_byte,
//                                           read_valid, read_last, done_res, status
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word is taken every cycle while out is not stalled; each tick word yields exactly
// one result word, passing through the input register and then the result register,
// set by the single pass of bus-sequencer logic between them.
// Reset (rst_n low, asynchronous) returns the bus sequencer to idle with lines released
// and loads the default timing registers; no clearing pass is needed.
// A stall on out holds the result register and backs up into in_stall.
// cfg_ready is always high; write timing registers only while the bus is idle.
module i2c_register_access_master (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [6:0]  dev_addr,
    input  logic [7:0]  reg_addr,
    input  logic [7:0]  write_data,
    input  logic [7:0]  read_len,
    input  logic        sda_sample,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_level,
    output logic        sda_pull_low,
    output logic        busy_res,
    output logic [7:0]  read_byte,
    output logic        read_valid,
    output logic        read_last,
    output logic        done_res,
    output logic        status,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import i2cram_pkg::*;

    // Input register: holds one tick word ahead of the sequencer.
    logic    in_full_reg, in_full_next;
    item_t   item_reg;

    // Result register: holds the word the downstream side has not yet taken.
    logic    out_valid_reg, out_valid_next;
    result_t result_reg;
    result_t engine_result;

    // Timing registers.
    logic [15:0] half_period_reg;
    logic [15:0] ack_timeout_reg;
    timing_t     timing;

    logic in_accept;
    logic advance;

    // Process the held tick when the result register is free or draining this cycle.
    assign advance   = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign timing.half_period = half_period_reg;
    assign timing.ack_timeout = ack_timeout_reg;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_accept)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    i2cram_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .timing (timing),
        .result (engine_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on handshake, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.cmd        <= cmd;
            item_reg.dev_addr   <= dev_addr;
            item_reg.reg_addr   <= reg_addr;
            item_reg.write_data <= write_data;
            item_reg.read_len   <= read_len;
            item_reg.sda_sample <= sda_sample;
        end
        if (advance)
        begin
            result_reg <= engine_result;
        end
    end

    // Timing registers; writes to unknown indexes drop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD: half_period_reg <= cfg_data;
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign scl_level    = result_reg.scl_level;
    assign sda_pull_low = result_reg.sda_pull_low;
    assign busy_res     = result_reg.busy_res;
    assign read_byte    = result_reg.read_byte;
    assign read_valid   = result_reg.read_valid;
    assign read_last    = result_reg.read_last;
    assign done_res     = result_reg.done_res;
    assign status       = result_reg.status;

endmodule

/* rtl/core/i2cram_engine.sv */
module i2cram_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  i2cram_pkg::item_t   item,
    input  i2cram_pkg::timing_t timing,
    output i2cram_pkg::result_t result
);
    import i2cram_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_RS_A,
        PH_RS_B,
        PH_BIT_SET,
        PH_BIT_HI,
        PH_BIT_LO,
        PH_WAIT_ACK,
        PH_ACK_HI,
        PH_ACK_LO,
        PH_READ_LO,
        PH_READ_HI,
        PH_AOUT_SET,
        PH_AOUT_HI,
        PH_AOUT_LO,
        PH_STOP_A,
        PH_STOP_B,
        PH_STOP_C
    } phase_t;

    // Which header byte goes out next.
    typedef enum logic [1:0] {
        STG_ADDR,
        STG_REG,
        STG_DATA
    } stage_t;

    phase_t      phase_reg, phase_next, cur_phase;
    stage_t      stage_reg, stage_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [15:0] hold_count_reg, hold_count_next;
    logic [15:0] wait_count_reg, wait_count_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [6:0]  dev_addr_reg, dev_addr_next;
    logic [7:0]  reg_addr_reg, reg_addr_next;
    logic [7:0]  write_data_reg, write_data_next;
    logic        is_read_reg, is_read_next;
    logic        failed_reg, failed_next;

    logic        start_req;
    logic [15:0] hp, to;
    logic [7:0]  len;
    logic [16:0] hold_inc, wait_inc;
    logic [3:0]  bit_inc;
    result_t     res;

    function automatic logic [7:0] load_value(input stage_t st, input logic rd,
                                              input logic [6:0] dev, input logic [7:0] rg,
                                              input logic [7:0] wd);
        logic [7:0] v;
        case (st)
            STG_ADDR: v = {dev, 1'b0};
            STG_REG:  v = rg;
            default:  v = rd ? {dev, 1'b1} : wd;
        endcase
        return v;
    endfunction

    always_comb
    begin
        phase_next      = phase_reg;
        stage_next      = stage_reg;
        bit_count_next  = bit_count_reg;
        shift_byte_next = shift_byte_reg;
        hold_count_next = hold_count_reg;
        wait_count_next = wait_count_reg;
        bytes_left_next = bytes_left_reg;
        dev_addr_next   = dev_addr_reg;
        reg_addr_next   = reg_addr_reg;
        write_data_next = write_data_reg;
        is_read_next    = is_read_reg;
        failed_next     = failed_reg;
        res             = '0;
        res.scl_level   = 1'b1;
        hold_inc        = '0;
        wait_inc        = '0;
        bit_inc         = '0;

        hp = (timing.half_period == 16'd0) ? 16'd1 : timing.half_period;
        to = (timing.ack_timeout == 16'd0) ? 16'd1 : timing.ack_timeout;

        len = (item.read_len == 8'd0) ? 8'd1 : item.read_len;
        if (len > MAX_BURST)
        begin
            len = MAX_BURST;
        end

        // Latch a new request only from idle.
        start_req = (phase_reg == PH_IDLE) &&
                    ((item.cmd == CMD_WRITE) || (item.cmd == CMD_READ));
        if (start_req)
        begin
            is_read_next    = (item.cmd == CMD_READ);
            dev_addr_next   = item.dev_addr;
            reg_addr_next   = item.reg_addr;
            write_data_next = is_read_next ? 8'd0 : item.write_data;
            bytes_left_next = is_read_next ? len : 8'd0;
            stage_next      = STG_ADDR;
            failed_next     = 1'b0;
            phase_next      = PH_START_A;
            hold_count_next = '0;
        end

        cur_phase = phase_next;

        if (cur_phase != PH_IDLE)
        begin
            // Line levels for the phase held during this tick.
            case (cur_phase)
                PH_START_A:
                begin
                    res.scl_level = 1'b1; res.sda_pull_low = 1'b1;
                end
                PH_START_B, PH_STOP_A:
                begin
                    res.scl_level = 1'b0; res.sda_pull_low = 1'b1;
                end
                PH_RS_A, PH_WAIT_ACK, PH_ACK_LO, PH_READ_LO:
                begin
                    res.scl_level = 1'b0; res.sda_pull_low = 1'b0;
                end
                PH_RS_B, PH_ACK_HI, PH_READ_HI:
                begin
                    res.scl_level = 1'b1; res.sda_pull_low = 1'b0;
                end
                PH_BIT_SET, PH_BIT_LO:
                begin
                    res.scl_level = 1'b0; res.sda_pull_low = ~shift_byte_next[7];
                end
                PH_BIT_HI:
                begin
                    res.scl_level = 1'b1; res.sda_pull_low = ~shift_byte_next[7];
                end
                PH_AOUT_SET, PH_AOUT_LO:
                begin
                    res.scl_level = 1'b0; res.sda_pull_low = (bytes_left_next != 8'd0);
                end
                PH_AOUT_HI:
                begin
                    res.scl_level = 1'b1; res.sda_pull_low = (bytes_left_next != 8'd0);
                end
                PH_STOP_B:
                begin
                    res.scl_level = 1'b1; res.sda_pull_low = 1'b1;
                end
                default:
                begin
                    res.scl_level = 1'b1; res.sda_pull_low = 1'b0;
                end
            endcase

            if (cur_phase == PH_WAIT_ACK)
            begin
                if (!item.sda_sample)
                begin
                    phase_next      = PH_ACK_HI;
                    hold_count_next = '0;
                end
                else
                begin
                    wait_inc        = {1'b0, wait_count_reg} + 17'd1;
                    wait_count_next = wait_inc[15:0];
                    if (wait_inc >= {1'b0, to})
                    begin
                        failed_next     = 1'b1;
                        phase_next      = PH_STOP_A;
                        hold_count_next = '0;
                    end
                end
            end
            else
            begin
                hold_inc        = {1'b0, hold_count_next} + 17'd1;
                hold_count_next = hold_inc[15:0];
                if (hold_inc >= {1'b0, hp})
                begin
                    hold_count_next = '0;
                    case (cur_phase)
                        PH_START_A:  phase_next = PH_START_B;
                        PH_START_B:
                        begin
                            shift_byte_next = load_value(stage_next, is_read_next,
                                                         dev_addr_next, reg_addr_next,
                                                         write_data_next);
                            bit_count_next  = '0;
                            phase_next      = PH_BIT_SET;
                        end
                        PH_RS_A:     phase_next = PH_RS_B;
                        PH_RS_B:     phase_next = PH_START_A;
                        PH_BIT_SET:  phase_next = PH_BIT_HI;
                        PH_BIT_HI:   phase_next = PH_BIT_LO;
                        PH_BIT_LO:
                        begin
                            shift_byte_next = {shift_byte_next[6:0], 1'b0};
                            bit_inc         = bit_count_next + 4'd1;
                            bit_count_next  = bit_inc;
                            if (bit_inc >= 4'd8)
                            begin
                                wait_count_next = '0;
                                phase_next      = PH_WAIT_ACK;
                            end
                            else
                            begin
                                phase_next = PH_BIT_SET;
                            end
                        end
                        PH_ACK_HI:   phase_next = PH_ACK_LO;
                        PH_ACK_LO:
                        begin
                            case (stage_next)
                                STG_ADDR:
                                begin
                                    stage_next      = STG_REG;
                                    shift_byte_next = load_value(STG_REG, is_read_next,
                                                                 dev_addr_next, reg_addr_next,
                                                                 write_data_next);
                                    bit_count_next  = '0;
                                    phase_next      = PH_BIT_SET;
                                end
                                STG_REG:
                                begin
                                    stage_next = STG_DATA;
                                    if (is_read_next)
                                    begin
                                        phase_next = PH_RS_A;
                                    end
                                    else
                                    begin
                                        shift_byte_next = load_value(STG_DATA, is_read_next,
                                                                     dev_addr_next,
                                                                     reg_addr_next,
                                                                     write_data_next);
                                        bit_count_next  = '0;
                                        phase_next      = PH_BIT_SET;
                                    end
                                end
                                default:
                                begin
                                    if (is_read_next)
                                    begin
                                        bit_count_next  = '0;
                                        shift_byte_next = '0;
                                        phase_next      = PH_READ_LO;
                                    end
                                    else
                                    begin
                                        phase_next = PH_STOP_A;
                                    end
                                end
                            endcase
                        end
                        PH_READ_LO:  phase_next = PH_READ_HI;
                        PH_READ_HI:
                        begin
                            shift_byte_next = {shift_byte_next[6:0], item.sda_sample};
                            bit_inc         = bit_count_next + 4'd1;
                            bit_count_next  = bit_inc;
                            if (bit_inc >= 4'd8)
                            begin
                                if (bytes_left_next != 8'd0)
                                begin
                                    bytes_left_next = bytes_left_next - 8'd1;
                                end
                                res.read_byte  = shift_byte_next;
                                res.read_valid = 1'b1;
                                res.read_last  = (bytes_left_next == 8'd0);
                                phase_next     = PH_AOUT_SET;
                            end
                            else
                            begin
                                phase_next = PH_READ_LO;
                            end
                        end
                        PH_AOUT_SET: phase_next = PH_AOUT_HI;
                        PH_AOUT_HI:  phase_next = PH_AOUT_LO;
                        PH_AOUT_LO:
                        begin
                            if (bytes_left_next == 8'd0)
                            begin
                                phase_next = PH_STOP_A;
                            end
                            else
                            begin
                                bit_count_next  = '0;
                                shift_byte_next = '0;
                                phase_next      = PH_READ_LO;
                            end
                        end
                        PH_STOP_A:   phase_next = PH_STOP_B;
                        PH_STOP_B:   phase_next = PH_STOP_C;
                        PH_STOP_C:
                        begin
                            res.done_res = 1'b1;
                            res.status   = failed_next;
                            phase_next   = PH_IDLE;
                        end
                        default:     phase_next = PH_IDLE;
                    endcase
                end
            end
        end

        res.busy_res = (phase_next != PH_IDLE);
    end

    assign result = res;

    // Advance the bus state once per processed tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            stage_reg      <= STG_ADDR;
            bit_count_reg  <= '0;
            shift_byte_reg <= '0;
            hold_count_reg <= '0;
            wait_count_reg <= '0;
            bytes_left_reg <= '0;
            dev_addr_reg   <= '0;
            reg_addr_reg   <= '0;
            write_data_reg <= '0;
            is_read_reg    <= 1'b0;
            failed_reg     <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            stage_reg      <= stage_next;
            bit_count_reg  <= bit_count_next;
            shift_byte_reg <= shift_byte_next;
            hold_count_reg <= hold_count_next;
            wait_count_reg <= wait_count_next;
            bytes_left_reg <= bytes_left_next;
            dev_addr_reg   <= dev_addr_next;
            reg_addr_reg   <= reg_addr_next;
            write_data_reg <= write_data_next;
            is_read_reg    <= is_read_next;
            failed_reg     <= failed_next;
        end
    end

endmodule
